FILE: src/lae_pkg.sv
// Shared types and constants for the life automaton engine.
// Used by lae_rule_cell and life_automaton_engine; depends on nothing.
`default_nettype none

package lae_pkg;

   localparam int CFG_W        = 7;
   localparam int IDX_W        = 6;
   localparam int CMD_W        = 2;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_TOGGLE = 2'd2,
      CMD_STEP   = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   // Three-by-three neighborhood of one cell, lowest column in bit 0.
   typedef struct packed {
      logic [2:0] above;
      logic [2:0] middle;
      logic [2:0] below;
   } cell_window_type;

endpackage

`default_nettype wire

FILE: src/life_automaton_engine.sv
// Top level of the life automaton engine: row chain, per-column rule cells and sequencer.
// Depends on lae_pkg, lae_row_cell and lae_rule_cell.
//
// Usage: each item on the req_ channel carries one command (req_tuser): read, write or
// toggle the cell at (row, column), or advance the grid by one B3/S23 generation.
// Every item yields exactly one item on the rsp_ channel whose bit 0 is the addressed
// cell after the command, or 0 after a step or an access outside the grid in use.
// The grid rows circulate through a chain of MAX_ROWS row registers; every command
// rotates the chain once, so the row under work is always at the head of the chain.
// An item is accepted in the idle state and then rotates the chain through all MAX_ROWS
// rows, the last of which loads the result register; no new item is accepted until
// that rotation is through. The result register lets the next item be accepted while
// a result waits; if the receiver still holds off rsp_tready when the following result
// is done, the block waits with that result and accepts nothing until it can be stored.
// Reset clears the whole grid to dead cells and sets both size registers to 64.
// The size registers are written through the csr_ port; the user must write them only
// while no item is in flight, as the block itself does not enforce it.
`default_nettype none

module life_automaton_engine #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: row_index [5:0], col_index [11:6], cell_value [12], zero [15:13]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lae_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: command [1:0]
   input  logic [lae_pkg::CMD_W-1:0]          req_tuser,
   // rsp_tdata: cell_alive [0], zero [7:1]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lae_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [lae_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lae_pkg::CFG_W-1:0]          csr_wdata
);

   import lae_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RSW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
   localparam int CSW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
   localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_PEND = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [RW-1:0]     count_ff, count_in;
   command_type       cmd_ff, cmd_in;
   logic [IDX_W-1:0]  row_idx_ff, row_idx_in;
   logic [IDX_W-1:0]  col_idx_ff, col_idx_in;
   logic              value_ff, value_in;
   logic              result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_alive_ff, rsp_alive_in;
   logic [CFG_W-1:0]  grid_rows_ff, grid_cols_ff;
   logic [MAX_COLS-1:0] above_ff, above_in;

   logic [RSW-1:0]    rows_ext, rows_use, count_ext;
   logic [CSW-1:0]    cols_ext, cols_use;
   logic              req_accept, shift_en, last_row, rsp_free;
   logic              row_active, below_active, row_hit, hit_alive, step_cmd;

   logic [MAX_COLS-1:0] chain [MAX_ROWS];
   logic [MAX_COLS-1:0] head, tail_row, step_row, access_row, col_mask, col_hit;
   logic [MAX_COLS-1:0] above_eff, above_m, head_m, below_m;
   logic [MAX_COLS+1:0] above_p, head_p, below_p;

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_SIZE_RESET;
         grid_cols_ff <= GRID_SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rows_ext = RSW'(grid_rows_ff);
   assign cols_ext = CSW'(grid_cols_ff);
   assign rows_use = (rows_ext > RSW'(MAX_ROWS)) ? RSW'(MAX_ROWS) : rows_ext;
   assign cols_use = (cols_ext > CSW'(MAX_COLS)) ? CSW'(MAX_COLS) : cols_ext;

   // Row chain: the head cell holds the row under work, the tail takes its new value.
   assign shift_en = (state_ff == ST_RUN);

   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_row
      if (k == MAX_ROWS - 1) begin : g_tail
         lae_row_cell #(.WIDTH(MAX_COLS)) u_row (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .row_in   (tail_row),
            .row_out  (chain[k])
         );
      end else begin : g_body
         lae_row_cell #(.WIDTH(MAX_COLS)) u_row (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .row_in   (chain[k+1]),
            .row_out  (chain[k])
         );
      end
   end

   assign head         = chain[0];
   assign count_ext    = RSW'(count_ff);
   assign row_active   = count_ext < rows_use;
   assign below_active = (count_ext + RSW'(1)) < rows_use;
   assign step_cmd     = (cmd_ff == CMD_STEP);
   assign last_row     = (count_ff == LAST_ROW);

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      lae_pkg::cell_window_type window;

      assign col_mask[j] = CSW'(j) < cols_use;
      assign col_hit[j]  = row_hit && (CSW'(j) == CSW'(col_idx_ff));

      assign window.above  = above_p[j+2:j];
      assign window.middle = {head_p[j+2], head[j], head_p[j]};
      assign window.below  = below_p[j+2:j];

      lae_rule_cell u_rule (
         .window     (window),
         .apply      (step_cmd && row_active && col_mask[j]),
         .next_alive (step_row[j])
      );
   end

   assign above_eff = (count_ff == '0) ? '0 : above_ff;
   assign above_m   = above_eff & col_mask;
   assign head_m    = head & col_mask;
   assign below_m   = below_active ? (chain[1] & col_mask) : '0;
   assign above_p   = {1'b0, above_m, 1'b0};
   assign head_p    = {1'b0, head_m, 1'b0};
   assign below_p   = {1'b0, below_m, 1'b0};

   // Cell access on the row that sits at the head of the chain.
   assign row_hit = !step_cmd && (count_ext == RSW'(row_idx_ff))
                 && (RSW'(row_idx_ff) < rows_use) && (CSW'(col_idx_ff) < cols_use);

   always_comb begin
      case (cmd_ff)
         CMD_WRITE:  access_row = (head & ~col_hit) | (col_hit & {MAX_COLS{value_ff}});
         CMD_TOGGLE: access_row = head ^ col_hit;
         default:    access_row = head;
      endcase
   end

   assign hit_alive = |(access_row & col_hit);
   assign tail_row  = step_cmd ? step_row : access_row;

   // Sequencer.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      row_idx_in   = row_idx_ff;
      col_idx_in   = col_idx_ff;
      value_in     = value_ff;
      result_in    = result_ff;
      above_in     = above_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_alive_in = rsp_alive_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in   = ST_RUN;
               count_in   = '0;
               cmd_in     = command_type'(req_tuser);
               row_idx_in = req_tdata[IDX_W-1:0];
               col_idx_in = req_tdata[2*IDX_W-1:IDX_W];
               value_in   = req_tdata[2*IDX_W];
               result_in  = 1'b0;
            end
         end
         ST_RUN: begin
            above_in  = head;
            result_in = result_ff | hit_alive;
            if (last_row) begin
               count_in = '0;
               if (rsp_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_alive_in = result_ff | hit_alive;
               end else begin
                  state_in = ST_PEND;
               end
            end else begin
               count_in = count_ff + RW'(1);
            end
         end
         ST_PEND: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_alive_in = result_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_idx_ff   <= row_idx_in;
      col_idx_ff   <= col_idx_in;
      value_ff     <= value_in;
      result_ff    <= result_in;
      above_ff     <= above_in;
      rsp_alive_ff <= rsp_alive_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_alive_ff);

   // An accepted item always starts a full rotation from the first row.
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN) && (count_ff == '0))
      else $error("accepted item did not start a rotation");

   // A rotation ends once its last row has been shifted.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && last_row |=> (state_ff != ST_RUN))
      else $error("rotation ran past the last row");

   // Between items the chain is back in its home position.
   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff == '0))
      else $error("row counter not at home while idle");

   // No result appears without an item having finished its rotation.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result presented without a finished item");

endmodule

`default_nettype wire

FILE: src/lae_row_cell.sv
// One stage of the row chain: holds one grid row and takes its neighbor's row on a shift.
// Standalone; instantiated once per grid row by life_automaton_engine.
`default_nettype none

module lae_row_cell #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] row_in,
   output logic [WIDTH-1:0] row_out
);

   logic [WIDTH-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (shift_en) begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

`default_nettype wire

FILE: src/lae_rule_cell.sv
// B3/S23 update of one cell from its three-by-three neighborhood.
// Depends on lae_pkg for the neighborhood type.
`default_nettype none

module lae_rule_cell (
   input  lae_pkg::cell_window_type window,
   input  logic                     apply,
   output logic                     next_alive
);

   import lae_pkg::*;

   logic [3:0] neighbors;
   logic       center;
   logic       rule_alive;

   assign center = window.middle[1];

   assign neighbors = 4'(window.above[0]) + 4'(window.above[1]) + 4'(window.above[2])
                    + 4'(window.middle[0]) + 4'(window.middle[2])
                    + 4'(window.below[0]) + 4'(window.below[1]) + 4'(window.below[2]);

   always_comb begin
      if (center) begin
         rule_alive = (neighbors == 4'd2) || (neighbors == 4'd3);
      end else begin
         rule_alive = (neighbors == 4'd3);
      end
   end

   assign next_alive = apply ? rule_alive : center;

endmodule

`default_nettype wire

FILE: verif/life_automaton_engine_test.sv
// Self-checking testbench for life_automaton_engine: cell reads, writes, toggles and
// B3/S23 generations are checked against a bit-level grid predictor under random idling.
// Depends on lae_pkg and life_automaton_engine.
`timescale 1ns / 100ps

module life_automaton_engine_test;
   import lae_pkg::*;

   localparam int MAX_DIM       = 64;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      command_type cmd;
      logic [5:0]  row;
      logic [5:0]  col;
      logic        alive;
   } pending_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   logic [MAX_DIM-1:0]    life_grid [MAX_DIM];
   logic [CFG_W-1:0]      rows_reg;
   logic [CFG_W-1:0]      cols_reg;
   pending_result_type    pending_results [$];
   pending_result_type    oldest_result;

   bit idle_on = 1'b1;
   int ready_left = 0;
   int error_count = 0;
   int item_count = 0;
   int result_count = 0;
   int size_writes = 0;
   int command_count [4];

   life_automaton_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int sat_size(logic [CFG_W-1:0] value);
      return (int'(value) > MAX_DIM) ? MAX_DIM : int'(value);
   endfunction

   // The row above and the current row are taken before each row is rewritten in place.
   function automatic void advance_generation();
      int rows_used;
      int cols_used;
      int n;
      int jj;
      logic [MAX_DIM-1:0] above_old;
      logic [MAX_DIM-1:0] this_old;
      rows_used = sat_size(rows_reg);
      cols_used = sat_size(cols_reg);
      above_old = '0;
      for (int i = 0; i < rows_used; i++) begin
         this_old = life_grid[i];
         for (int j = 0; j < cols_used; j++) begin
            n = 0;
            for (int dc = -1; dc <= 1; dc++) begin
               jj = j + dc;
               if (jj < 0 || jj >= cols_used) continue;
               n += above_old[jj];
               if (dc != 0) n += this_old[jj];
               if (i + 1 < rows_used) n += life_grid[i+1][jj];
            end
            if (this_old[j]) life_grid[i][j] = (n == 2 || n == 3);
            else life_grid[i][j] = (n == 3);
         end
         above_old = this_old;
      end
   endfunction

   function automatic logic predict_cell_alive(command_type cmd, logic [5:0] row,
                                               logic [5:0] col, logic val);
      if (cmd == CMD_STEP) begin
         advance_generation();
         return 1'b0;
      end
      if (int'(row) >= sat_size(rows_reg) || int'(col) >= sat_size(cols_reg)) return 1'b0;
      case (cmd)
         CMD_WRITE: begin
            life_grid[row][col] = val;
         end
         CMD_TOGGLE: begin
            life_grid[row][col] = ~life_grid[row][col];
         end
         default: begin
         end
      endcase
      return life_grid[row][col];
   endfunction

   function automatic logic [CFG_W-1:0] pick_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return CFG_W'($urandom_range(1, 10));
      else if (pick < 75) return 7'd64;
      else if (pick < 80) return 7'd127;
      else if (pick < 85) return CFG_W'($urandom_range(65, 126));
      else if (pick < 90) return 7'd0;
      else if (pick < 93) return 7'd1;
      else return CFG_W'($urandom_range(1, 64));
   endfunction

   // Mostly a coordinate inside a six-cell window of the grid in use, sometimes anywhere.
   function automatic logic [5:0] pick_near(int base, int size);
      int v;
      if (size == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      v = base + $urandom_range(0, 5);
      if (v >= size) v = $urandom_range(0, size - 1);
      return 6'(v);
   endfunction

   task automatic send_item(input command_type cmd, input logic [5:0] row,
                            input logic [5:0] col, input logic val);
      int gap;
      pending_result_type entry;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, val, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.cmd   = cmd;
      entry.row   = row;
      entry.col   = col;
      entry.alive = predict_cell_alive(cmd, row, col, val);
      pending_results.push_back(entry);
      item_count++;
      command_count[cmd]++;
   endtask

   task automatic send_noise();
      send_item(command_type'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input csr_index_type which, input logic [CFG_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (which == CSR_GRID_ROWS) rows_reg = value;
      else cols_reg = value;
      size_writes++;
   endtask

   task automatic run_life_phase();
      int rows_used;
      int cols_used;
      int row_base;
      int col_base;
      write_size(CSR_GRID_ROWS, pick_size());
      write_size(CSR_GRID_COLS, pick_size());
      rows_used = sat_size(rows_reg);
      cols_used = sat_size(cols_reg);
      row_base = (rows_used > 6) ? $urandom_range(0, rows_used - 6) : 0;
      col_base = (cols_used > 6) ? $urandom_range(0, cols_used - 6) : 0;
      repeat ($urandom_range(3, 30)) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_item(($urandom_range(0, 3) == 0) ? CMD_TOGGLE : CMD_WRITE,
                        pick_near(row_base, rows_used), pick_near(col_base, cols_used),
                        $urandom_range(0, 9) < 6);
      end
      repeat ($urandom_range(1, 4)) begin
         send_item(CMD_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)));
         repeat ($urandom_range(2, 8))
            send_item(CMD_READ, pick_near(row_base, rows_used),
                      pick_near(col_base, cols_used), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_directed_access();
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_WRITE, 63, 63, 1);
      send_item(CMD_READ, 63, 63, 0);
      send_item(CMD_TOGGLE, 0, 0, 1);
      send_item(CMD_TOGGLE, 0, 0, 0);
      send_item(CMD_WRITE, 63, 63, 0);
      // A vertical blinker turns horizontal and back.
      send_item(CMD_WRITE, 10, 20, 1);
      send_item(CMD_WRITE, 11, 20, 1);
      send_item(CMD_WRITE, 12, 20, 1);
      send_item(CMD_STEP, 63, 63, 1);
      send_item(CMD_READ, 11, 19, 0);
      send_item(CMD_READ, 11, 21, 0);
      send_item(CMD_READ, 10, 20, 0);
      send_item(CMD_STEP, 0, 0, 0);
      send_item(CMD_READ, 10, 20, 0);
   endtask

   task automatic test_size_limits();
      write_size(CSR_GRID_ROWS, 7'd127);
      write_size(CSR_GRID_COLS, 7'd100);
      send_item(CMD_READ, 12, 20, 0);
      write_size(CSR_GRID_ROWS, 7'd0);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_WRITE, 0, 0, 1);
      send_item(CMD_STEP, 0, 0, 0);
      // On a three-by-three grid, an L of three cells in the corner grows into a block.
      write_size(CSR_GRID_ROWS, 7'd3);
      write_size(CSR_GRID_COLS, 7'd3);
      send_item(CMD_WRITE, 0, 3, 1);
      send_item(CMD_TOGGLE, 3, 0, 0);
      send_item(CMD_WRITE, 0, 0, 1);
      send_item(CMD_WRITE, 0, 1, 1);
      send_item(CMD_WRITE, 1, 0, 1);
      send_item(CMD_STEP, 0, 0, 0);
      send_item(CMD_READ, 1, 1, 0);
      // The blinker outside the small grid was left alone and shows again.
      write_size(CSR_GRID_ROWS, 7'd64);
      write_size(CSR_GRID_COLS, 7'd64);
      send_item(CMD_READ, 11, 20, 0);
   endtask

   task automatic test_random_life(input int target);
      while (item_count < target) run_life_phase();
   endtask

   task automatic test_full_rate(input int count);
      int stop_at;
      stop_at = item_count + count;
      idle_on = 1'b0;
      while (item_count < stop_at) run_life_phase();
   endtask

   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_tready <= 1'b1;
         ready_left = 0;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(0, 15);
         end else begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(0, 47);
         end
      end else begin
         ready_left = ready_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("rsp item with nothing pending: cell_alive %0b", rsp_tdata[0]);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            result_count++;
            if (rsp_tdata[0] !== oldest_result.alive) begin
               $error("cell_alive after %s (%0d,%0d): expected %0b, actual %0b",
                      oldest_result.cmd.name(), oldest_result.row, oldest_result.col,
                      oldest_result.alive, rsp_tdata[0]);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < MAX_DIM; i++) life_grid[i] = '0;
      rows_reg = GRID_SIZE_RESET;
      cols_reg = GRID_SIZE_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_access();
      test_size_limits();
      test_random_life(900);
      test_full_rate(150);

      wait_for_results();
      repeat (MAX_DIM + 8) @(posedge clock);
      $display("Ran %0d items: %0d reads, %0d writes, %0d toggles, %0d steps; %0d size writes.",
               item_count, command_count[CMD_READ], command_count[CMD_WRITE],
               command_count[CMD_TOGGLE], command_count[CMD_STEP], size_writes);
      $display("Checked %0d results, %0d mismatches.", result_count, error_count);
      if (error_count == 0) begin
         $display("life_automaton_engine test passed");
      end else begin
         $display("life_automaton_engine test failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d results still pending.", pending_results.size());
      $display("life_automaton_engine test failed");
      $finish;
   end

endmodule
